>>> rtl/core/life_automaton_row_step_defines.svh
// Assertion macros shared by the row-step checker.
`ifndef LIFE_AUTOMATON_ROW_STEP_DEFINES_SVH
`define LIFE_AUTOMATON_ROW_STEP_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define LARS_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("row step check failed");

// Next-cycle implication, disabled while dis is high.
`define LARS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("row step check failed");

`endif

>>> rtl/core/lars_pkg.sv
// Package: shared widths, defaults and the B3/S23 cell rule.
`default_nettype none

package lars_pkg;

    localparam int ROW_BITS          = 64;  // cells carried by one row transfer
    localparam int WIDTH_BITS        = 7;   // row_width register
    localparam int DEFAULT_MAX_WIDTH = 64;
    localparam int RESULT_Q_DEPTH    = 4;   // result queue entries

    localparam logic [WIDTH_BITS-1:0] RESET_ROW_WIDTH = 7'd64;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_cells;
        logic                last_of_grid;
    } lars_result_t;

    // live next generation: exactly three neighbors, or two and live now
    function automatic logic lars_rule(input logic [3:0] count, input logic alive);
        lars_rule = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && alive);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/life_automaton_row_step.sv
// Top level: B3/S23 one-generation row streamer with result queue.
// One row per cycle while s_tready is high; a final row queues up to two results,
// drained one per cycle while m_tready is high.
// s_tready holds while the 4-entry result queue has room for two more results.
// Reset (aresetn low, synchronous): queue empty, no rows held, row_width back to 64.
`default_nettype none

module life_automaton_row_step
    import lars_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // row in
    input  logic [ROW_BITS-1:0]   s_tdata,   // row_cells[63:0]
    input  logic                  s_tlast,   // final_row
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // result out
    output logic [ROW_BITS-1:0]   m_tdata,   // next_cells[63:0]
    output logic                  m_tlast,   // last_of_grid
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // row_width register write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WIDTH_BITS-1:0] cfg_data   // row_width[6:0]
);

    localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);
    localparam int PTR_W = $clog2(RESULT_Q_DEPTH);
    localparam int CNT_W = $clog2(RESULT_Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(RESULT_Q_DEPTH - 2);

    // ---------------- configuration ----------------
    logic [WIDTH_BITS-1:0] width_reg;
    logic [WIDTH_BITS-1:0] eff_width;
    logic [MAX_WIDTH-1:0]  col_mask;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= RESET_ROW_WIDTH;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    // widths beyond the lane count saturate
    assign eff_width = (width_reg > MAX_W) ? MAX_W : width_reg;

    always_comb begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            col_mask[k] = (WIDTH_BITS'(k) < eff_width);
        end
    end

    // ---------------- row window ----------------
    // have_row_reg: a row of this grid is held in middle_reg, its result still owed.
    // above_reg is the row over it (zero when it is the top row).
    logic                 have_row_reg, have_row_next;
    logic [MAX_WIDTH-1:0] above_reg, above_next;
    logic [MAX_WIDTH-1:0] middle_reg, middle_next;
    logic [MAX_WIDTH-1:0] in_row;
    logic                 in_xfer;

    assign in_row  = s_tdata[MAX_WIDTH-1:0] & col_mask;
    assign in_xfer = s_tvalid && s_tready;

    // evaluator A: result for the held row, or for a lone single-row grid
    // evaluator B: the final row's own result, dead row below
    logic [MAX_WIDTH-1:0] a_up, a_mid, a_down;
    logic [MAX_WIDTH-1:0] a_next, b_next;

    assign a_up   = have_row_reg ? above_reg  : '0;
    assign a_mid  = have_row_reg ? middle_reg : in_row;
    assign a_down = have_row_reg ? in_row     : '0;

    lars_row_eval #(.MAX_WIDTH(MAX_WIDTH)) u_eval_a (
        .row_up  (a_up),
        .row_mid (a_mid),
        .row_down(a_down),
        .col_mask(col_mask),
        .row_next(a_next)
    );

    lars_row_eval #(.MAX_WIDTH(MAX_WIDTH)) u_eval_b (
        .row_up  (middle_reg),
        .row_mid (in_row),
        .row_down('0),
        .col_mask(col_mask),
        .row_next(b_next)
    );

    logic push_a, push_b;

    assign push_a = in_xfer && (have_row_reg || s_tlast);
    assign push_b = in_xfer && have_row_reg && s_tlast;

    always_comb begin
        have_row_next = have_row_reg;
        above_next    = above_reg;
        middle_next   = middle_reg;
        if (in_xfer) begin
            if (s_tlast) begin
                have_row_next = 1'b0;   // grid done, ready for the next one
            end else begin
                have_row_next = 1'b1;
                above_next    = have_row_reg ? middle_reg : '0;
                middle_next   = in_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_row_reg <= 1'b0;
        end else begin
            have_row_reg <= have_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        above_reg  <= above_next;
        middle_reg <= middle_next;
    end

    // ---------------- result queue ----------------
    lars_result_t         res_q_reg [RESULT_Q_DEPTH];
    lars_result_t         res_a, res_b;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, wr_ptr_b;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     push_cnt;
    logic                 pop;

    // a lone row is its own bottom; the held row's result is never last
    assign res_a.next_cells   = ROW_BITS'(a_next);
    assign res_a.last_of_grid = !have_row_reg;
    assign res_b.next_cells   = ROW_BITS'(b_next);
    assign res_b.last_of_grid = 1'b1;

    assign wr_ptr_b = wr_ptr_reg + PTR_W'(1);
    assign push_cnt = CNT_W'(push_a) + CNT_W'(push_b);
    assign pop      = m_tvalid && m_tready;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_cnt - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            res_q_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b) begin
            res_q_reg[wr_ptr_b] <= res_b;
        end
    end

    // room for the two results a final row may bring
    assign s_tready = (count_reg <= READY_LIMIT);

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = res_q_reg[rd_ptr_reg].next_cells;
    assign m_tlast  = res_q_reg[rd_ptr_reg].last_of_grid;

endmodule

`default_nettype wire

>>> rtl/core/lars_lane.sv
// One cell lane: 3x3 window neighbor count and next-state rule.
`default_nettype none

module lars_lane
    import lars_pkg::*;
(
    input  logic [2:0] up_win,
    input  logic [2:0] mid_win,
    input  logic [2:0] down_win,
    output logic       cell_next
);

    logic [3:0] count;

    assign count = 4'(up_win[0]) + 4'(up_win[1]) + 4'(up_win[2])
                 + 4'(mid_win[0]) + 4'(mid_win[2])
                 + 4'(down_win[0]) + 4'(down_win[1]) + 4'(down_win[2]);

    assign cell_next = lars_rule(count, mid_win[1]);

endmodule

`default_nettype wire

>>> rtl/core/lars_row_eval.sv
// Row evaluator: one lane per column, merged into a masked next-generation row.
`default_nettype none

module lars_row_eval
    import lars_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic [MAX_WIDTH-1:0] row_up,
    input  logic [MAX_WIDTH-1:0] row_mid,
    input  logic [MAX_WIDTH-1:0] row_down,
    input  logic [MAX_WIDTH-1:0] col_mask,
    output logic [MAX_WIDTH-1:0] row_next
);

    // dead column padded on both edges
    logic [MAX_WIDTH+1:0] up_pad;
    logic [MAX_WIDTH+1:0] mid_pad;
    logic [MAX_WIDTH+1:0] down_pad;
    logic [MAX_WIDTH-1:0] lane_out;

    assign up_pad   = {1'b0, row_up   & col_mask, 1'b0};
    assign mid_pad  = {1'b0, row_mid  & col_mask, 1'b0};
    assign down_pad = {1'b0, row_down & col_mask, 1'b0};

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_lane
        lars_lane u_lane (
            .up_win   (up_pad[k+2:k]),
            .mid_win  (mid_pad[k+2:k]),
            .down_win (down_pad[k+2:k]),
            .cell_next(lane_out[k])
        );
    end

    // merge: columns outside the active width read as dead
    assign row_next = lane_out & col_mask;

endmodule

`default_nettype wire

>>> rtl/core/lars_checker.sv
// Port-level checker for the row-step block, bound to the top level.
`default_nettype none
`include "life_automaton_row_step_defines.svh"

module lars_checker
    import lars_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [ROW_BITS-1:0]   m_tdata,
    input  logic                  m_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [WIDTH_BITS-1:0] cfg_data
);

    // shadow of the width register, seen from the config port
    logic [WIDTH_BITS-1:0] width_reg;
    logic [ROW_BITS-1:0]   hi_mask;
    logic                  in_last_xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= RESET_ROW_WIDTH;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    // columns at or above the width
    assign hi_mask = (width_reg >= WIDTH_BITS'(ROW_BITS)) ? '0
                   : ~((ROW_BITS'(1) << width_reg) - ROW_BITS'(1));

    assign in_last_xfer = s_tvalid && s_tready && s_tlast;

    `LARS_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_tvalid)
    `LARS_ASSERT_NEXT(a_last_row_result, aclk, !aresetn, in_last_xfer, m_tvalid)
    `LARS_ASSERT_NOW(a_unused_cols_dead, aclk, !aresetn, m_tvalid, (m_tdata & hi_mask) == '0)
    `LARS_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind life_automaton_row_step lars_checker u_lars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
);

`default_nettype wire

>>> test/tb_life_automaton_row_step.sv
// Testbench for life_automaton_row_step: streams grids, predicts each generation row, checks them.
`default_nettype none

module tb_life_automaton_row_step;
    import lars_pkg::*;

    localparam int RANDOM_ROWS = 1100;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 80;     // receiver hold-off that fills the result queue
    localparam int SETTLE      = 4;      // cycles after the last result before a width write
    localparam int NUM_DIRECTED = 19;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                last;
    } gen_row_t;

    // typed = 1: the row starts and ends a grid and its one result is written out here
    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                fin;
        logic                typed;
        logic [ROW_BITS-1:0] want_cells;
        logic                want_last;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
        // one-row grids at full width
        '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1},
        '{64'h0000_0000_0000_0001, 1'b1, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
        '{64'h0000_0000_0000_0007, 1'b1, 1'b1, 64'h0000_0000_0000_0002, 1'b1},
        // blinker
        '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'h0000_0000_0000_0007, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
        // solid block
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
        // cells on both edge columns
        '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'hC000_0000_0000_0003, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0, 1'b0},
        // checkerboard, then a two-row mixed grid
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'hFFFF_0000_FFFF_0000, 1'b1, 1'b0, 64'h0, 1'b0},
        '{64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 64'h0, 1'b0},
        '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0, 1'b0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [ROW_BITS-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ROW_BITS-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [WIDTH_BITS-1:0] cfg_data  = '0;

    life_automaton_row_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),     // row_cells[63:0]
        .s_tlast   (s_tlast),     // final_row
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),     // next_cells[63:0]
        .m_tlast   (m_tlast),     // last_of_grid
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)     // row_width[6:0]
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor: a private copy of the width register and held rows
    // ---------------------------------------------------------------
    logic [WIDTH_BITS-1:0] width_setting = RESET_ROW_WIDTH;
    logic [ROW_BITS-1:0]   held_above    = '0;
    logic [ROW_BITS-1:0]   held_middle   = '0;
    logic [1:0]            rows_held     = 2'd0;   // 0 none, 1 one row, 2 two or more
    gen_row_t              rows_due [$];           // generation rows still owed by the block

    // widths past 64 saturate; zero leaves no cell in use
    function automatic logic [ROW_BITS-1:0] lane_mask(input logic [WIDTH_BITS-1:0] w);
        if (w >= 7'd64)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [ROW_BITS-1:0] evolve_row(input logic [ROW_BITS-1:0] up,
                                                       input logic [ROW_BITS-1:0] mid,
                                                       input logic [ROW_BITS-1:0] down,
                                                       input logic [ROW_BITS-1:0] mask);
        logic [ROW_BITS-1:0] u;
        logic [ROW_BITS-1:0] c;
        logic [ROW_BITS-1:0] d;
        logic [ROW_BITS-1:0] born;
        int                  n;
        u    = up & mask;
        c    = mid & mask;
        d    = down & mask;
        born = '0;
        for (int k = 0; k < ROW_BITS; k++) begin
            n = int'(u[k]) + int'(d[k]);
            if (k > 0)
                n += int'(u[k-1]) + int'(c[k-1]) + int'(d[k-1]);
            if (k < ROW_BITS - 1)
                n += int'(u[k+1]) + int'(c[k+1]) + int'(d[k+1]);
            born[k] = (n == 3) || ((n == 2) && c[k]);
        end
        return born & mask;
    endfunction

    // advance the held rows by one accepted row; record = 0 keeps the results out of rows_due
    task automatic advance_grid(input logic [ROW_BITS-1:0] cells, input logic fin,
                                input bit record);
        logic [ROW_BITS-1:0] mask;
        logic [ROW_BITS-1:0] r;
        mask = lane_mask(width_setting);
        r    = cells & mask;
        if (rows_held == 2'd0) begin
            if (fin) begin
                if (record)
                    rows_due.push_back(gen_row_t'{evolve_row('0, r, '0, mask), 1'b1});
                held_above  = '0;
                held_middle = '0;
            end else begin
                held_above  = '0;
                held_middle = r;
                rows_held   = 2'd1;
            end
        end else begin
            if (record)
                rows_due.push_back(gen_row_t'{evolve_row(held_above, held_middle, r, mask), 1'b0});
            if (fin) begin
                if (record)
                    rows_due.push_back(gen_row_t'{evolve_row(held_middle, r, '0, mask), 1'b1});
                held_above  = '0;
                held_middle = '0;
                rows_held   = 2'd0;
            end else begin
                held_above  = held_middle;
                held_middle = r;
                rows_held   = 2'd2;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    int       mismatch_count = 0;
    gen_row_t oldest_row;

    task automatic note_mismatch(input string what, input gen_row_t want, input gen_row_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected cells %h last %0b, got cells %h last %0b",
                     what, want.cells, want.last, got.cells, got.last);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (rows_due.size() == 0) begin
                note_mismatch("unexpected result row", '0, gen_row_t'{m_tdata, m_tlast});
            end else begin
                oldest_row = rows_due.pop_front();
                if (m_tdata !== oldest_row.cells || m_tlast !== oldest_row.last)
                    note_mismatch("result row", oldest_row, gen_row_t'{m_tdata, m_tlast});
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: changing stall patterns plus requested long hold-offs
    // ---------------------------------------------------------------
    int hold_requests = 0;   // written by the stimulus only
    int holds_served  = 0;   // written by the receiver only
    int hold_left     = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    int stall_phase   = 0;

    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            stall_phase = (stall_phase + 1) % 3;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;                              // no stalls
                    1: m_tready <= ($urandom_range(0, 1) == 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);       // mostly stalled
                    default: m_tready <= (stall_phase == 0);          // ready only when stall_phase is zero
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    int burst_left = 0;

    // offer one row and hold it until the transfer; then maybe idle
    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic fin,
                            input bit typed, input gen_row_t typed_result);
        int gap;
        s_tdata  <= cells;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        advance_grid(cells, fin, !typed);
        if (typed)
            rows_due.push_back(typed_result);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // stop offering and wait until every owed row has come out
    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_width(input logic [WIDTH_BITS-1:0] w);
        drain_results(SETTLE);
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        width_setting  = w;
    endtask

    // extremes first, then mostly in-range widths with the odd saturating one
    function automatic logic [WIDTH_BITS-1:0] pick_width(input int phase);
        case (phase)
            0: return 7'd1;
            1: return 7'd64;
            2: return 7'd0;
            3: return 7'd2;
            4: return 7'd127;
            5: return 7'd3;
            6: return 7'd63;
            7: return 7'd65;
            default: begin
                if ($urandom_range(0, 5) == 0)
                    return 7'($urandom_range(0, 127));
                return 7'($urandom_range(1, 64));
            end
        endcase
    endfunction

    function automatic logic [ROW_BITS-1:0] random_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return a & b;
            1: return a & b & {$urandom, $urandom};   // sparse
            2: return a | b;                          // dense
            3: return '1;
            4: return '0;
            5: return 64'd7 << $urandom_range(0, 61);
            default: return a;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int rows_sent;
        int grid_left;
        int phase_left;
        int phase_no;
        rows_sent  = 0;
        grid_left  = 0;
        phase_left = 0;
        phase_no   = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at the reset width
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_row(DIRECTED_ROWS[i].cells, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
                     gen_row_t'{DIRECTED_ROWS[i].want_cells, DIRECTED_ROWS[i].want_last});

        // random grids; width phases may end in the middle of a grid
        while (rows_sent < RANDOM_ROWS) begin
            if (phase_left == 0) begin
                write_width(pick_width(phase_no));
                phase_no++;
                phase_left = $urandom_range(60, 140);
            end
            if (grid_left == 0)
                grid_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                        : $urandom_range(1, 6);
            if (rows_sent == 300 || rows_sent == 800)
                hold_requests++;
            send_row(random_row(), grid_left == 1, 1'b0, '0);
            grid_left--;
            phase_left--;
            rows_sent++;
        end

        drain_results(8);
        if (mismatch_count == 0 && rows_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
